/* hw/rtl/wfur_pkg.sv */
// Shared types and constants for the WebSocket frame unmask and reframe block.
package wfur_pkg;

  // Depth of the command queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Header values of the received frames and of the re-framed output.
  localparam logic [7:0] TextFrameHdr = 8'h81;
  localparam logic [3:0] OpcodeClose  = 4'h8;
  localparam logic [6:0] LenCodeMax7  = 7'd125;
  localparam logic [6:0] LenCode16    = 7'd126;
  localparam logic [3:0] ExtBytes16   = 4'd2;
  localparam logic [3:0] ExtBytes64   = 4'd8;

  // Kinds of work that the parser hands to the output stage.
  typedef enum logic [1:0] {
    CMD_EMIT  = 2'd0,  // pass a header byte through, never unmasked
    CMD_CLOSE = 2'd1,  // report a close frame
    CMD_KEY   = 2'd2,  // shift one mask key byte in, no result
    CMD_PAY   = 2'd3   // unmask one payload byte
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] key_idx;
    logic       unmask;
  } cmd_t;

endpackage

/* hw/rtl/wfur_front.sv */
// Frame parser: tracks header, length, mask key and payload phases per byte.
module wfur_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_start_i,
  output logic            cmd_valid_o,
  output wfur_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] pay_left_q, pay_left_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic        mask_on_q, mask_on_d;
  logic        dropping_q, dropping_d;

  logic [63:0] ext_len;
  logic [3:0]  ext_left_dec;
  logic [1:0]  mask_idx_inc;
  logic [6:0]  len_code;

  assign ext_len      = {pay_left_q[55:0], rx_byte_i};
  assign ext_left_dec = ext_left_q - 4'd1;
  assign mask_idx_inc = mask_idx_q + 2'd1;
  assign len_code     = rx_byte_i[6:0];

  // Next state and the command for the byte just accepted.
  always_comb begin
    phase_d     = phase_q;
    ext_left_d  = ext_left_q;
    pay_left_d  = pay_left_q;
    mask_idx_d  = mask_idx_q;
    mask_on_d   = mask_on_q;
    dropping_d  = dropping_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: wfur_pkg::CMD_EMIT, data: rx_byte_i, last: 1'b0,
                    key_idx: mask_idx_q, unmask: mask_on_q};
    if (accept_i) begin
      if (frame_start_i) begin
        dropping_d  = 1'b0;
        ext_left_d  = '0;
        pay_left_d  = '0;
        mask_idx_d  = '0;
        mask_on_d   = 1'b0;
        cmd_valid_o = 1'b1;
        if (rx_byte_i[3:0] == wfur_pkg::OpcodeClose) begin
          dropping_d = 1'b1;
          phase_d    = PH_HDR0;
          cmd_o.kind = wfur_pkg::CMD_CLOSE;
          cmd_o.data = '0;
          cmd_o.last = 1'b1;
        end else begin
          phase_d    = PH_HDR1;
          cmd_o.data = wfur_pkg::TextFrameHdr;
        end
      end else if (!dropping_q) begin
        case (phase_q)
          PH_HDR1: begin
            cmd_valid_o = 1'b1;
            cmd_o.data  = {1'b0, len_code};
            mask_on_d   = rx_byte_i[7];
            if (len_code <= wfur_pkg::LenCodeMax7) begin
              pay_left_d = {57'd0, len_code};
              mask_idx_d = '0;
              cmd_o.last = (len_code == 7'd0);
              if (rx_byte_i[7]) begin
                phase_d = PH_MASK;
              end else if (len_code == 7'd0) begin
                phase_d = PH_HDR0;
              end else begin
                phase_d = PH_PAY;
              end
            end else begin
              ext_left_d = (len_code == wfur_pkg::LenCode16) ?
                           wfur_pkg::ExtBytes16 : wfur_pkg::ExtBytes64;
              pay_left_d = '0;
              phase_d    = PH_EXT;
            end
          end
          PH_EXT: begin
            cmd_valid_o = 1'b1;
            pay_left_d  = ext_len;
            ext_left_d  = ext_left_dec;
            if (ext_left_dec == 4'd0) begin
              cmd_o.last = (ext_len == 64'd0);
              mask_idx_d = '0;
              if (mask_on_q) begin
                phase_d = PH_MASK;
              end else if (ext_len == 64'd0) begin
                phase_d = PH_HDR0;
              end else begin
                phase_d = PH_PAY;
              end
            end
          end
          PH_MASK: begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = wfur_pkg::CMD_KEY;
            mask_idx_d  = mask_idx_inc;
            if (mask_idx_inc == 2'd0) begin
              phase_d = (pay_left_q == 64'd0) ? PH_HDR0 : PH_PAY;
            end
          end
          PH_PAY: begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = wfur_pkg::CMD_PAY;
            cmd_o.last  = (pay_left_q == 64'd1);
            mask_idx_d  = mask_idx_inc;
            pay_left_d  = pay_left_q - 64'd1;
            if (pay_left_q == 64'd1) begin
              phase_d = PH_HDR0;
            end
          end
          default: begin
            // No frame in progress: the byte is ignored.
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      ext_left_q <= '0;
      pay_left_q <= '0;
      mask_idx_q <= '0;
      mask_on_q  <= 1'b0;
      dropping_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      pay_left_q <= pay_left_d;
      mask_idx_q <= mask_idx_d;
      mask_on_q  <= mask_on_d;
      dropping_q <= dropping_d;
    end
  end

endmodule

/* hw/rtl/wfur_queue.sv */
// Short command queue between the parser and the output stage.
module wfur_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  wfur_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output wfur_pkg::cmd_t rd_data_o,
  output logic           empty_o
);

  wfur_pkg::cmd_t                        mem_q [wfur_pkg::QueueDepth];
  logic [wfur_pkg::QueuePtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [wfur_pkg::QueueCntW-1:0]        count_q;
  logic                                  do_wr, do_rd;

  assign full_o    = (count_q == wfur_pkg::QueueCntW'(wfur_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage for the waiting commands.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + wfur_pkg::QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + wfur_pkg::QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + wfur_pkg::QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - wfur_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/wfur_back.sv */
// Output stage: holds the mask key, unmasks payload and registers the result item.
module wfur_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_avail_i,
  input  wfur_pkg::cmd_t cmd_i,
  output logic           cmd_take_o,
  output logic [7:0]     out_byte_o,
  output logic           last_of_frame_o,
  output logic           close_seen_o,
  output logic           empty_o,
  input  logic           pop_i
);

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        last_q, close_q;
  logic [31:0] key_q;
  logic [7:0]  key_byte;
  logic        can_load;
  logic        is_key;

  assign empty_o         = !out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_frame_o = last_q;
  assign close_seen_o    = close_q;

  // Key bytes are consumed at once; others wait for a free output register.
  assign is_key     = (cmd_i.kind == wfur_pkg::CMD_KEY);
  assign can_load   = !out_valid_q || pop_i;
  assign cmd_take_o = cmd_avail_i && (is_key || can_load);

  // The first key byte sits in the top byte of the key register.
  always_comb begin
    case (cmd_i.key_idx)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Mask key shift register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cmd_take_o && is_key) begin
      key_q <= {key_q[23:0], cmd_i.data};
    end
  end

  // Result item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_take_o && !is_key) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && !is_key) begin
      out_byte_q <= (cmd_i.kind == wfur_pkg::CMD_PAY && cmd_i.unmask) ?
                    (cmd_i.data ^ key_byte) : cmd_i.data;
      last_q     <= cmd_i.last;
      close_q    <= (cmd_i.kind == wfur_pkg::CMD_CLOSE);
    end
  end

endmodule

/* hw/rtl/websocket_frame_unmask_reframe.sv */
// Top level of the WebSocket frame unmask and reframe block.
// Takes one received client frame byte per cycle (push while full is low) and
// gives the frame back as an unmasked text frame: 0x81, the length code, any
// extended length bytes, then the payload, XORed with the mask key if the
// frame is masked. Mask key bytes and the bytes of a close frame after its
// first give no result item; a close frame gives a single item with
// close_seen set. An item that gives a result is decoded by the parser in the
// accepting cycle and written as a command into a four-entry queue; the output
// stage then moves it into the result register when the result side is free.
// Sustained rate is one item per cycle; full rises only when the result side
// stalls long enough to fill the queue.
module websocket_frame_unmask_reframe (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_frame_o,
  output logic       close_seen_o
);

  logic           accept;
  logic           cmd_valid;
  wfur_pkg::cmd_t cmd;
  wfur_pkg::cmd_t q_data;
  logic           q_empty;
  logic           q_take;

  assign accept = push && !full;

  // Parser front end.
  wfur_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  // Queue between parser and output stage.
  wfur_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_i      (q_take),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  // Output stage.
  wfur_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_avail_i     (!q_empty),
    .cmd_i           (q_data),
    .cmd_take_o      (q_take),
    .out_byte_o      (out_byte_o),
    .last_of_frame_o (last_of_frame_o),
    .close_seen_o    (close_seen_o),
    .empty_o         (empty),
    .pop_i           (pop)
  );

endmodule
